[design/tfp_pkg.sv]
// Package for the TLV frame parser: header state codes, result record and
// configuration register map. No dependencies.
`default_nettype none

package tfp_pkg;

   localparam int BYTE_BITS  = 8;
   localparam int LEN_BYTES  = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int TDATA_W    = 48;

   // csr register index
   localparam logic CSR_LENGTH_ORDER = 1'b0;

   typedef enum logic [2:0] {
      ST_TYPE    = 3'd0,
      ST_LEN0    = 3'd1,
      ST_LEN1    = 3'd2,
      ST_LEN2    = 3'd3,
      ST_LEN3    = 3'd4,
      ST_PAYLOAD = 3'd5
   } tfp_state_type;

   typedef struct packed {
      logic [31:0]          frame_length;
      logic                 empty_frame;
      logic                 is_last;
      logic [BYTE_BITS-1:0] payload_byte;
      logic [BYTE_BITS-1:0] frame_type;
   } tfp_result_type;

   typedef struct packed {
      logic           valid;
      tfp_result_type data;
   } tfp_push_type;

endpackage

`default_nettype wire

[design/tfp_parse.sv]
// Header decoder and payload tracker of the TLV frame parser.
// Depends on tfp_pkg.
`default_nettype none

module tfp_parse
   import tfp_pkg::*;
#(
   parameter int LENGTH_WIDTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_accept,
   input  wire logic [BYTE_BITS-1:0] in_byte,
   input  wire logic                 length_msb_first,
   output tfp_push_type              push
);

   tfp_state_type             state_ff, state_in;
   logic [BYTE_BITS-1:0]      type_ff, type_in;
   logic [LENGTH_WIDTH-1:0]   acc_ff, acc_in;
   logic [LENGTH_WIDTH-1:0]   rem_ff, rem_in;

   logic [LENGTH_WIDTH+BYTE_BITS-1:0] msb_word;
   logic [31:0]                       lsb_word;
   logic [1:0]                        byte_sel;
   logic [LENGTH_WIDTH-1:0]           acc_new;
   logic                              last;

   assign msb_word = {acc_ff, in_byte};
   assign lsb_word = 32'(in_byte) << {byte_sel, 3'b000};
   assign acc_new  = length_msb_first ? msb_word[LENGTH_WIDTH-1:0]
                                      : (acc_ff | lsb_word[LENGTH_WIDTH-1:0]);
   assign last     = (rem_ff <= LENGTH_WIDTH'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_TYPE;
      end else begin
         state_ff <= state_in;
      end
      type_ff <= type_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
   end

   always_comb begin
      state_in  = state_ff;
      type_in   = type_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      byte_sel  = 2'd0;
      push      = '0;
      push.data.frame_type   = type_ff;
      push.data.frame_length = 32'(acc_ff);
      unique case (state_ff)
         ST_LEN0, ST_LEN1, ST_LEN2, ST_LEN3: begin
            byte_sel = 2'(state_ff - ST_LEN0);
            if (in_accept) begin
               acc_in = acc_new;
               if (state_ff != ST_LEN3) begin
                  state_in = tfp_state_type'(state_ff + 3'd1);
               end else if (acc_new == '0) begin
                  push.valid             = 1'b1;
                  push.data.is_last      = 1'b1;
                  push.data.empty_frame  = 1'b1;
                  push.data.frame_length = 32'(acc_new);
                  state_in               = ST_TYPE;
               end else begin
                  rem_in   = acc_new;
                  state_in = ST_PAYLOAD;
               end
            end
         end
         ST_PAYLOAD: begin
            push.data.payload_byte = in_byte;
            push.data.is_last      = last;
            if (in_accept) begin
               push.valid = 1'b1;
               if (rem_ff != '0) begin
                  rem_in = rem_ff - LENGTH_WIDTH'(1);
               end
               if (last) begin
                  state_in = ST_TYPE;
               end
            end
         end
         default: begin
            if (in_accept) begin
               type_in  = in_byte;
               acc_in   = '0;
               rem_in   = '0;
               state_in = ST_LEN0;
            end
         end
      endcase
   end

endmodule

`default_nettype wire

[design/tfp_rsp_buf.sv]
// Two-entry result buffer of the TLV frame parser; decouples the result
// channel from the byte input. Depends on tfp_pkg.
`default_nettype none

module tfp_rsp_buf
   import tfp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  tfp_push_type  push,
   output logic          in_ready,
   output logic          out_valid,
   input  wire logic     out_ready,
   output tfp_result_type out_data
);

   logic [1:0]     count_ff, count_in;
   tfp_result_type head_ff, head_in;
   tfp_result_type tail_ff, tail_in;
   logic           pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = head_ff;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      case (count_ff)
         2'd0: begin
            if (push.valid) begin
               head_in  = push.data;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (push.valid && pop) begin
               head_in = push.data;
            end else if (push.valid) begin
               tail_in  = push.data;
               count_in = 2'd2;
            end else if (pop) begin
               count_in = 2'd0;
            end
         end
         default: begin
            if (pop) begin
               head_in  = tail_ff;
               count_in = 2'd1;
            end
         end
      endcase
   end

endmodule

`default_nettype wire

[design/tlv_frame_parser.sv]
// TLV frame parser: one result per payload byte, one marked result per empty frame.
// A result is registered in the result buffer before it is offered on rsp.
// Throughput: one byte per cycle; a two-entry result buffer keeps req open while
// a result waits, and req stalls only when both entries are held.
// Reset clears the header state, the result buffer and the length order register.
// Depends on tfp_pkg, tfp_parse and tfp_rsp_buf.
`default_nettype none

module tlv_frame_parser
   import tfp_pkg::*;
#(
   parameter int LENGTH_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // in_byte
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [TDATA_W-1:0]         rsp_tdata,   // frame_type, payload_byte, frame_length
   output logic                       rsp_tlast,   // is_last
   output logic                       rsp_tuser,   // empty_frame
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   logic           msb_first_ff, msb_first_in;
   logic           csr_write;
   logic           csr_hit;
   logic           in_accept;
   tfp_push_type   push;
   tfp_result_type head;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == CSR_LENGTH_ORDER);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_hit ? {31'b0, msb_first_ff} : 32'b0;

   always_comb begin
      msb_first_in = msb_first_ff;
      if (csr_write && csr_hit) begin
         msb_first_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msb_first_ff <= 1'b0;
      end else begin
         msb_first_ff <= msb_first_in;
      end
   end

   assign in_accept = req_tvalid && req_tready;

   tfp_parse #(
      .LENGTH_WIDTH(LENGTH_WIDTH)
   ) u_parse (
      .clock            (clock),
      .reset            (reset),
      .in_accept        (in_accept),
      .in_byte          (req_tdata),
      .length_msb_first (msb_first_ff),
      .push             (push)
   );

   tfp_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head)
   );

   assign rsp_tdata = {head.frame_length, head.payload_byte, head.frame_type};
   assign rsp_tlast = head.is_last;
   assign rsp_tuser = head.empty_frame;

endmodule

`default_nettype wire

[design/tfp_checker.sv]
// Port-level checks for the TLV frame parser, bound to tlv_frame_parser.
// Depends on tfp_pkg.
`default_nettype none

module tfp_checker
   import tfp_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_tvalid,
   input wire logic               req_tready,
   input wire logic               rsp_tvalid,
   input wire logic               rsp_tready,
   input wire logic [TDATA_W-1:0] rsp_tdata,
   input wire logic               rsp_tlast,
   input wire logic               rsp_tuser
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // empty frame: single last result, zero byte, zero length
   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata[15:8] == 8'd0)
         && (rsp_tdata[47:16] == 32'd0))
      else $error("malformed empty-frame result");

   // payload results carry a nonzero length
   a_payload_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata[47:16] != 32'd0))
      else $error("payload result with zero length");

   // a new result needs an accepted byte in the cycle before
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result without an accepted byte");

endmodule

bind tlv_frame_parser tfp_checker u_tfp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

[tb/tb_tlv_frame_parser.sv]
// Testbench for tlv_frame_parser: drives a byte stream of type-length-value frames with
// random gaps and stalls, predicts every result and compares it field by field.
// Depends on tfp_pkg and the tlv_frame_parser RTL.
`default_nettype none

module tb_tlv_frame_parser;
   import tfp_pkg::*;

   localparam int LEN_W          = 32;
   localparam int RANDOM_ITEMS   = 1600;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PLAN_ROWS      = 28;
   localparam logic [CSR_ADDR_W-1:0] ADDR_LENGTH_ORDER = CSR_ADDR_W'(CSR_LENGTH_ORDER) << 2;
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED     = 3'd4;

   typedef enum logic {ROW_BYTE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [CSR_ADDR_W-1:0] addr;
      logic [31:0]           value;
      logic                  checked;
      tfp_result_type        want;
   } stim_row_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata   = '0;   // in_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [TDATA_W-1:0]    rsp_tdata;          // frame_type, payload_byte, frame_length
   logic                  rsp_tlast;          // is_last
   logic                  rsp_tuser;          // empty_frame
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // parser state as predicted
   tfp_state_type  hdr_state      = ST_TYPE;
   logic [7:0]     cur_type       = '0;
   logic [31:0]    cur_length     = '0;
   logic [31:0]    payload_left   = '0;
   logic           msb_first      = 1'b0;

   tfp_result_type pending_results [$];
   stim_row_type   plan [PLAN_ROWS];
   int             errors         = 0;
   int             bytes_accepted = 0;
   int             idle_cycles    = 0;
   bit             calm           = 1'b0;

   tlv_frame_parser #(.LENGTH_WIDTH(LEN_W)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int draw_gap();
      return calm ? 0 : int'($urandom_range(0, 17));
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, output tfp_result_type res);
      bit produced;
      produced = 1'b0;
      res      = '0;
      case (hdr_state)
         ST_LEN0, ST_LEN1, ST_LEN2, ST_LEN3: begin
            if (msb_first) begin
               cur_length = {cur_length[23:0], b};
            end else begin
               cur_length = cur_length | (32'(b) << (BYTE_BITS * (int'(hdr_state) - 1)));
            end
            if (hdr_state != ST_LEN3) begin
               hdr_state = tfp_state_type'(hdr_state + 3'd1);
            end else begin
               cur_length = cur_length & 32'((64'd1 << LEN_W) - 64'd1);
               if (cur_length == 0) begin
                  res.frame_type   = cur_type;
                  res.is_last      = 1'b1;
                  res.empty_frame  = 1'b1;
                  res.frame_length = cur_length;
                  hdr_state        = ST_TYPE;
                  produced         = 1'b1;
               end else begin
                  payload_left = cur_length;
                  hdr_state    = ST_PAYLOAD;
               end
            end
         end
         ST_PAYLOAD: begin
            res.frame_type   = cur_type;
            res.payload_byte = b;
            res.is_last      = (payload_left <= 1);
            res.frame_length = cur_length;
            if (payload_left > 0) payload_left = payload_left - 1;
            if (res.is_last) hdr_state = ST_TYPE;
            produced = 1'b1;
         end
         default: begin
            cur_type     = b;
            cur_length   = '0;
            payload_left = '0;
            hdr_state    = ST_LEN0;
         end
      endcase
      return produced;
   endfunction

   function automatic stim_row_type byte_row(input logic [7:0] b);
      stim_row_type row;
      row       = '0;
      row.kind  = ROW_BYTE;
      row.value = 32'(b);
      return row;
   endfunction

   function automatic stim_row_type checked_row(input logic [7:0] b, input logic [7:0] ftype,
                                                input logic last, input logic empty,
                                                input logic [31:0] flen);
      stim_row_type row;
      row                   = byte_row(b);
      row.checked           = 1'b1;
      row.want.frame_type   = ftype;
      row.want.payload_byte = empty ? 8'h00 : b;
      row.want.is_last      = last;
      row.want.empty_frame  = empty;
      row.want.frame_length = flen;
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_ADDR_W-1:0] addr,
                                            input logic [31:0] value);
      stim_row_type row;
      row       = '0;
      row.kind  = ROW_CSR;
      row.addr  = addr;
      row.value = value;
      return row;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endtask

   // enter and leave at a falling edge; tvalid stays high on return
   task automatic send_byte(input logic [7:0] b, input bit checked, input tfp_result_type want);
      int             gap;
      tfp_result_type res;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_accepted++;
      if (parse_byte(b, res)) pending_results.push_back(checked ? want : res);
      @(negedge clock);
   endtask

   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_access(input bit wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr >> 2 == CSR_ADDR_W'(CSR_LENGTH_ORDER)) begin
         if (wr) msb_first = data[0];
         else check_field("length_msb_first", {31'b0, msb_first}, csr_prdata);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_order(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      quiesce();
      csr_access(1'b1, addr, data);
      csr_access(1'b0, ADDR_LENGTH_ORDER, '0);
   endtask

   // reorder: flip the length byte order partway through the header
   task automatic send_frame(input bit reorder);
      logic [31:0] len;
      logic [7:0]  hdr [4];
      int          pick;
      int          split;
      bit          new_order;
      pick      = $urandom_range(0, 99);
      len       = (pick < 10) ? 32'd0 :
                  (pick < 90) ? 32'($urandom_range(1, 16)) : 32'($urandom_range(17, 300));
      split     = reorder ? int'($urandom_range(1, 3)) : 4;
      new_order = !msb_first;
      foreach (hdr[k]) hdr[k] = msb_first ? len[8*(3-k) +: 8] : len[8*k +: 8];
      if (reorder) begin
         foreach (hdr[k]) hdr[k] = '0;
         hdr[new_order ? 3 : split - 1] = 8'(len[3:0]);
      end
      send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      for (int k = 0; k < 4; k++) begin
         if (k == split) write_order(ADDR_LENGTH_ORDER, ($urandom() & ~32'd1) | 32'(new_order));
         send_byte(hdr[k], 1'b0, '0);
      end
      if (hdr_state == ST_PAYLOAD) begin
         repeat (cur_length) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      end
   endtask

   initial begin
      int first_random;
      plan = '{
         byte_row(8'hFF),
         byte_row(8'h00), byte_row(8'h00), byte_row(8'h00),
         checked_row(8'h00, 8'hFF, 1'b1, 1'b1, 32'd0),
         byte_row(8'h00),
         byte_row(8'h01), byte_row(8'h00), byte_row(8'h00), byte_row(8'h00),
         checked_row(8'hFF, 8'h00, 1'b1, 1'b0, 32'd1),
         csr_row(ADDR_LENGTH_ORDER, 32'hFFFF_FFFF),
         csr_row(ADDR_UNMAPPED, 32'h0000_0000),
         byte_row(8'h5A),
         byte_row(8'h00), byte_row(8'h00), byte_row(8'h00), byte_row(8'h02),
         byte_row(8'h00),
         checked_row(8'h80, 8'h5A, 1'b1, 1'b0, 32'd2),
         byte_row(8'h3C),
         byte_row(8'h02),
         csr_row(ADDR_LENGTH_ORDER, 32'hFFFF_FFFE),
         byte_row(8'h00), byte_row(8'h00), byte_row(8'h00),
         byte_row(8'h7F),
         byte_row(8'h81)
      };
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      csr_access(1'b0, ADDR_LENGTH_ORDER, '0);
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) write_order(plan[i].addr, plan[i].value);
         else send_byte(plan[i].value[7:0], plan[i].checked, plan[i].want);
      end
      first_random = bytes_accepted;
      while (bytes_accepted < first_random + RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) calm = !calm;
         if ($urandom_range(0, 11) == 0) begin
            write_order(($urandom_range(0, 4) == 0) ? ADDR_UNMAPPED : ADDR_LENGTH_ORDER, $urandom());
         end
         send_frame($urandom_range(0, 9) == 0);
      end
      // longest length: every length bit set, cut off after a few payload bytes
      send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      repeat (4) send_byte(8'hFF, 1'b0, '0);
      repeat (8) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("tlv_frame_parser: match");
      end else begin
         $display("tlv_frame_parser: mismatch");
      end
      $finish;
   end

   initial begin
      int             gap;
      tfp_result_type want;
      while (reset) @(negedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (pending_results.size() == 0) begin
            $error("rsp transaction with no expected result");
            errors++;
         end else begin
            want = pending_results.pop_front();
            check_field("frame_type", 32'(want.frame_type), 32'(rsp_tdata[7:0]));
            check_field("payload_byte", 32'(want.payload_byte), 32'(rsp_tdata[15:8]));
            check_field("frame_length", want.frame_length, rsp_tdata[47:16]);
            check_field("is_last", 32'(want.is_last), 32'(rsp_tlast));
            check_field("empty_frame", 32'(want.empty_frame), 32'(rsp_tuser));
         end
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("tlv_frame_parser: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

`default_nettype wire

[sim.f]
design/tfp_pkg.sv
design/tfp_parse.sv
design/tfp_rsp_buf.sv
design/tlv_frame_parser.sv
design/tfp_checker.sv
tb/tb_tlv_frame_parser.sv
